// ----- sv/date_day_difference_top_assert.svh -----
// Assertion macros for the date day difference block.
`ifndef DATE_DAY_DIFFERENCE_TOP_ASSERT_SVH
`define DATE_DAY_DIFFERENCE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define DDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define DDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define DDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/ddd_pkg.sv -----
// Package with calendar constants, month tables and stage types for the day difference block.
`timescale 1ns / 1ps

package ddd_pkg;

    localparam logic [13:0] SwitchYear  = 14'd1582;
    localparam logic [3:0]  SwitchMonth = 4'd10;
    localparam logic [4:0]  SwitchDay   = 5'd15;
    localparam logic [4:0]  SkipFirst   = 5'd5;
    localparam logic [1:0]  GregShift   = 2'd2;
    // 2^19 / 100 rounded up; exact floor for all values below 16384.
    localparam logic [12:0] Recip100    = 13'd5243;
    localparam logic [8:0]  DaysPerYear = 9'd365;
    localparam logic [6:0]  Hundred     = 7'd100;
    localparam logic [22:0] MaxDiff     = 23'd6000000;

    localparam logic [3:0] MonJan = 4'd1;
    localparam logic [3:0] MonFeb = 4'd2;
    localparam logic [3:0] MonDec = 4'd12;

    typedef struct packed {
        logic        ok;
        logic        greg;
        logic [13:0] yr;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [26:0] yq;
        logic [22:0] p365;
        logic [11:0] q4;
        logic [26:0] pq;
        logic [24:0] q4q;
    } s1_t;

    typedef struct packed {
        logic        ok;
        logic        greg;
        logic [22:0] base;
        logic [7:0]  corr;
        logic [8:0]  mcd;
    } s2_t;

    typedef struct packed {
        logic        ok;
        logic [22:0] cnt;
    } s3_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = leap ? 5'd29 : 5'd28;
            default:                                     n = 5'd31;
        endcase
        return n;
    endfunction

    // Days in the months before month m of the same year.
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        if (leap && (m > MonFeb))
        begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

// ----- sv/date_day_difference_top.sv -----
// Top level: pipelined day difference between two Julian/Gregorian calendar dates.
// A beat accepted on start passes the stage-one, stage-two, stage-three and output registers before done.
// Throughput: one date pair per cycle; busy is always low since the receiver cannot stall.
// The four register stages are split around the constant multipliers, the month table
// and the final subtract. Reset clears the stage valid bits only; no result is pending after.
`timescale 1ns / 1ps
`include "date_day_difference_top_assert.svh"

module date_day_difference_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] first_year,
    input  logic [3:0]  first_month,
    input  logic [4:0]  first_day,
    input  logic [13:0] second_year,
    input  logic [3:0]  second_month,
    input  logic [4:0]  second_day,
    output logic        done,
    output logic        invalid_date,
    output logic [22:0] day_difference
);

    logic [13:0] yr_in  [2];
    logic [3:0]  mon_in [2];
    logic [4:0]  day_in [2];

    ddd_pkg::s1_t s1_reg [2];
    ddd_pkg::s1_t s1_next[2];
    ddd_pkg::s2_t s2_reg [2];
    ddd_pkg::s2_t s2_next[2];
    ddd_pkg::s3_t s3_reg [2];
    ddd_pkg::s3_t s3_next[2];

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, done_reg;
    logic        invalid_reg, invalid_next;
    logic [22:0] diff_reg, diff_next;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign yr_in[0]  = first_year;
    assign yr_in[1]  = second_year;
    assign mon_in[0] = first_month;
    assign mon_in[1] = second_month;
    assign day_in[0] = first_day;
    assign day_in[1] = second_day;

    for (genvar g = 0; g < 2; g++)
    begin : g_date
        logic [13:0] p;
        logic        skipped;
        logic [7:0]  yq100;
        logic [14:0] hund;
        logic        century;
        logic        leap;
        logic [4:0]  mlen;

        // Stage one: calendar choice, range checks and the constant multiplies.
        always_comb
        begin
            p       = yr_in[g] - 14'd1;
            skipped = (yr_in[g] == ddd_pkg::SwitchYear) && (mon_in[g] == ddd_pkg::SwitchMonth)
                      && (day_in[g] >= ddd_pkg::SkipFirst) && (day_in[g] < ddd_pkg::SwitchDay);
            s1_next[g].greg = (yr_in[g] > ddd_pkg::SwitchYear)
                || ((yr_in[g] == ddd_pkg::SwitchYear)
                    && ((mon_in[g] > ddd_pkg::SwitchMonth)
                        || ((mon_in[g] == ddd_pkg::SwitchMonth)
                            && (day_in[g] >= ddd_pkg::SwitchDay))));
            s1_next[g].ok   = (yr_in[g] != 14'd0) && (mon_in[g] >= ddd_pkg::MonJan)
                              && (mon_in[g] <= ddd_pkg::MonDec) && (day_in[g] != 5'd0)
                              && !skipped;
            s1_next[g].yr   = yr_in[g];
            s1_next[g].mon  = mon_in[g];
            s1_next[g].day  = day_in[g];
            s1_next[g].yq   = 27'(yr_in[g]) * 27'(ddd_pkg::Recip100);
            s1_next[g].p365 = 23'(p) * 23'(ddd_pkg::DaysPerYear);
            s1_next[g].q4   = p[13:2];
            s1_next[g].pq   = 27'(p) * 27'(ddd_pkg::Recip100);
            s1_next[g].q4q  = 25'(p[13:2]) * 25'(ddd_pkg::Recip100);
        end

        // Stage two: leap rule, day range check, month offset, year base and century correction.
        always_comb
        begin
            yq100   = s1_reg[g].yq[26:19];
            hund    = 15'(yq100) * 15'(ddd_pkg::Hundred);
            century = (15'(s1_reg[g].yr) == hund);
            // A year is divisible by 400 when it is a century year whose hundreds are
            // divisible by four.
            leap    = (s1_reg[g].yr[1:0] == 2'b00)
                      && (!s1_reg[g].greg || !century || (yq100[1:0] == 2'b00));
            mlen    = ddd_pkg::month_len(s1_reg[g].mon, leap);
            s2_next[g].ok   = s1_reg[g].ok && (s1_reg[g].day <= mlen);
            s2_next[g].greg = s1_reg[g].greg;
            s2_next[g].base = s1_reg[g].p365 + 23'(s1_reg[g].q4);
            s2_next[g].corr = s1_reg[g].pq[26:19] - 8'(s1_reg[g].q4q[24:19]);
            s2_next[g].mcd  = ddd_pkg::cum_days(s1_reg[g].mon, leap) + 9'(s1_reg[g].day);
        end

        // Stage three: full day count in the date's own calendar.
        always_comb
        begin
            s3_next[g].ok  = s2_reg[g].ok;
            s3_next[g].cnt = s2_reg[g].base + 23'(s2_reg[g].mcd)
                             + (s2_reg[g].greg ? 23'(ddd_pkg::GregShift) : 23'd0)
                             - (s2_reg[g].greg ? 23'(s2_reg[g].corr) : 23'd0);
        end

        always_ff @(posedge clk)
        begin
            s1_reg[g] <= s1_next[g];
            s2_reg[g] <= s2_next[g];
            s3_reg[g] <= s3_next[g];
        end
    end

    // Stage four: absolute difference, forced to zero on a bad date.
    always_comb
    begin
        invalid_next = !(s3_reg[0].ok && s3_reg[1].ok);
        if (invalid_next)
        begin
            diff_next = 23'd0;
        end
        else if (s3_reg[0].cnt >= s3_reg[1].cnt)
        begin
            diff_next = s3_reg[0].cnt - s3_reg[1].cnt;
        end
        else
        begin
            diff_next = s3_reg[1].cnt - s3_reg[0].cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        invalid_reg <= invalid_next;
        diff_reg    <= diff_next;
    end

    assign done           = done_reg;
    assign invalid_date   = invalid_reg;
    assign day_difference = diff_reg;

    `DDD_ASSERT_IMP(a_done_follows_start, clk, rst_n, done, $past(accept, 4))
    `DDD_ASSERT_IMP(a_invalid_zero, clk, rst_n, done && invalid_date, day_difference == 23'd0)
    `DDD_ASSERT_IMP(a_same_date_zero, clk, rst_n,
        done && $past(first_year == second_year && first_month == second_month
                      && first_day == second_day, 4),
        day_difference == 23'd0)
    `DDD_ASSERT_NXT(a_year_zero_bad, clk, rst_n, accept && (first_year == 14'd0), !s1_reg[0].ok)
    `DDD_ASSERT_IMP(a_diff_range, clk, rst_n, done, day_difference <= ddd_pkg::MaxDiff)

endmodule
